@@ design/psp_pkg.sv @@
`timescale 1ns / 1ps

package psp_pkg;

  // Guard bits below the integer coordinate in the CORDIC datapath.
  localparam int GUARD = 4;

  // Angle accumulator width: a full turn is 2^ZW.
  localparam int ZW = 32;

  // Converged CORDIC gain 0.6072529350 in Q24.
  localparam int GAIN_FRAC = 24;
  localparam int GW = 24;
  localparam logic [GW-1:0] GAIN_Q = 24'd10188014;

  localparam int MAX_STAGES = 24;

  // arctan(2^-i) as binary angles of a 32-bit full turn, rounded to nearest.
  localparam logic [ZW-1:0] ATAN_TURNS [0:MAX_STAGES-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic zero;
    logic back;
  } psp_side_t;

endpackage

@@ design/psp_cordic_stage.sv @@
`timescale 1ns / 1ps

module psp_cordic_stage #(
  parameter int XW    = 32,
  parameter int HW    = 16,
  parameter int SHIFT = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  psp_pkg::psp_side_t          side_i,
  input  logic [HW-1:0]               heading_i,
  input  logic signed [XW-1:0]        x_i,
  input  logic signed [XW-1:0]        y_i,
  input  logic [psp_pkg::ZW-1:0]      z_i,
  output logic                        valid_o,
  output psp_pkg::psp_side_t          side_o,
  output logic [HW-1:0]               heading_o,
  output logic signed [XW-1:0]        x_o,
  output logic signed [XW-1:0]        y_o,
  output logic [psp_pkg::ZW-1:0]      z_o
);

  logic signed [XW-1:0]       xs, ys, x_d, y_d;
  logic [psp_pkg::ZW-1:0]     z_d;
  logic                       valid_q;
  psp_pkg::psp_side_t         side_q;
  logic [HW-1:0]              heading_q;
  logic signed [XW-1:0]       x_q, y_q;
  logic [psp_pkg::ZW-1:0]     z_q;

  always_comb begin
    xs = x_i >>> SHIFT;
    ys = y_i >>> SHIFT;
    // Rotate towards the x axis: the sign of y picks the direction.
    if (y_i[XW-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - psp_pkg::ATAN_TURNS[SHIFT];
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + psp_pkg::ATAN_TURNS[SHIFT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q    <= side_i;
      heading_q <= heading_i;
      x_q       <= x_d;
      y_q       <= y_d;
      z_q       <= z_d;
    end
  end

  assign valid_o   = valid_q;
  assign side_o    = side_q;
  assign heading_o = heading_q;
  assign x_o       = x_q;
  assign y_o       = y_q;
  assign z_o       = z_q;

endmodule

@@ design/pose_to_segment_polar_top.sv @@
`timescale 1ns / 1ps
// Pipeline from an accepted input transaction to its result: set-up, one stage per
// CORDIC iteration, gain multiply, rounding and the output register.
// Throughput: one transaction per cycle while out_ready_i is high; every stage loads whenever it is empty or drains.
// Reset clears the valid bit of every stage; the data registers are not reset.
module pose_to_segment_polar_top #(
  parameter int COORD_BITS    = 24,
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_BITS-1:0]  cur_x_i,
  input  logic signed [COORD_BITS-1:0]  cur_y_i,
  input  logic signed [ANGLE_BITS-1:0]  cur_heading_i,
  input  logic signed [COORD_BITS-1:0]  target_x_i,
  input  logic signed [COORD_BITS-1:0]  target_y_i,
  input  logic                          backward_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_BITS+1:0]  length_o,
  output logic signed [ANGLE_BITS-1:0]  turn_o
);

  localparam int CW       = COORD_BITS;
  localparam int AB       = ANGLE_BITS;
  localparam int N        = CORDIC_STAGES;
  localparam int GUARD    = psp_pkg::GUARD;
  localparam int ZW       = psp_pkg::ZW;
  localparam int GW       = psp_pkg::GW;
  localparam int XW       = CW + 8;
  localparam int PW       = XW - 1 + GW;
  localparam int LEN_BITS = CW + 2;
  localparam int RSH      = psp_pkg::GAIN_FRAC + GUARD;
  localparam logic [ZW-1:0] Z_ROUND = {{(ZW-1){1'b0}}, 1'b1} << (ZW - 1 - AB);
  localparam logic [PW-1:0] P_ROUND = {{(PW-1){1'b0}}, 1'b1} << (RSH - 1);

  // Stage arrays: index 0 is the set-up stage, index k the k-th CORDIC iteration.
  logic                    v_s    [0:N];
  psp_pkg::psp_side_t      side_s [0:N];
  logic [AB-1:0]           head_s [0:N];
  logic signed [XW-1:0]    x_s    [0:N];
  logic signed [XW-1:0]    y_s    [0:N];
  logic [ZW-1:0]           z_s    [0:N];
  logic [N:0]              en_s;

  // Set-up stage.
  logic signed [CW:0]      dx, dy, dxa, dya;
  logic                    neg;
  logic signed [XW-1:0]    x0_d, y0_d;
  logic [ZW-1:0]           z0_d;
  psp_pkg::psp_side_t      side0_d;
  logic                    v0_q;
  psp_pkg::psp_side_t      side0_q;
  logic [AB-1:0]           head0_q;
  logic signed [XW-1:0]    x0_q, y0_q;
  logic [ZW-1:0]           z0_q;

  always_comb begin
    dx   = {target_x_i[CW-1], target_x_i} - {cur_x_i[CW-1], cur_x_i};
    dy   = {target_y_i[CW-1], target_y_i} - {cur_y_i[CW-1], cur_y_i};
    neg  = dx[CW];
    // The left half plane is folded over by a half turn before the iterations.
    dxa  = neg ? -dx : dx;
    dya  = neg ? -dy : dy;
    x0_d = {{(XW-CW-1-GUARD){dxa[CW]}}, dxa, {GUARD{1'b0}}};
    y0_d = {{(XW-CW-1-GUARD){dya[CW]}}, dya, {GUARD{1'b0}}};
    z0_d = {neg, {(ZW-1){1'b0}}};
    side0_d.zero = (dx == '0) && (dy == '0);
    side0_d.back = backward_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_s[0]) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_s[0]) begin
      side0_q <= side0_d;
      head0_q <= cur_heading_i;
      x0_q    <= x0_d;
      y0_q    <= y0_d;
      z0_q    <= z0_d;
    end
  end

  assign v_s[0]    = v0_q;
  assign side_s[0] = side0_q;
  assign head_s[0] = head0_q;
  assign x_s[0]    = x0_q;
  assign y_s[0]    = y0_q;
  assign z_s[0]    = z0_q;

  for (genvar k = 1; k <= N; k++) begin : g_cordic
    psp_cordic_stage #(
      .XW    (XW),
      .HW    (AB),
      .SHIFT (k - 1)
    ) u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en_s[k]),
      .valid_i   (v_s[k-1]),
      .side_i    (side_s[k-1]),
      .heading_i (head_s[k-1]),
      .x_i       (x_s[k-1]),
      .y_i       (y_s[k-1]),
      .z_i       (z_s[k-1]),
      .valid_o   (v_s[k]),
      .side_o    (side_s[k]),
      .heading_o (head_s[k]),
      .x_o       (x_s[k]),
      .y_o       (y_s[k]),
      .z_o       (z_s[k])
    );
  end

  // Gain multiply stage; the turn is settled here as well.
  logic                    en_m, en_r, en_o;
  logic [XW-2:0]           xmag;
  logic [ZW-1:0]           zsum;
  logic [AB-1:0]           bearing, turn_m_d;
  logic [PW-1:0]           prod_d;
  logic                    mv_q;
  psp_pkg::psp_side_t      m_side_q;
  logic [PW-1:0]           prod_q;
  logic [AB-1:0]           turn_m_q;

  always_comb begin
    xmag     = x_s[N][XW-1] ? '0 : x_s[N][XW-2:0];
    prod_d   = {{GW{1'b0}}, xmag} * {{(XW-1){1'b0}}, psp_pkg::GAIN_Q};
    zsum     = z_s[N] + Z_ROUND;
    bearing  = side_s[N].zero ? '0 : zsum[ZW-1 -: AB];
    turn_m_d = bearing - head_s[N];
    // Reversing subtracts a half turn, which only flips the top bit.
    turn_m_d[AB-1] = turn_m_d[AB-1] ^ side_s[N].back;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (en_m) begin
      mv_q <= v_s[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_m) begin
      m_side_q <= side_s[N];
      prod_q   <= prod_d;
      turn_m_q <= turn_m_d;
    end
  end

  // Rounding stage.
  logic [PW-1:0]           rnd;
  logic                    rv_q;
  psp_pkg::psp_side_t      r_side_q;
  logic [LEN_BITS-1:0]     len_r_q;
  logic [AB-1:0]           turn_r_q;

  assign rnd = prod_q + P_ROUND;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else if (en_r) begin
      rv_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_r) begin
      r_side_q <= m_side_q;
      len_r_q  <= rnd[RSH +: LEN_BITS];
      turn_r_q <= turn_m_q;
    end
  end

  // Output register.
  logic [LEN_BITS-1:0]     len_o_d;
  logic                    ov_q;
  psp_pkg::psp_side_t      o_side_q;
  logic [LEN_BITS-1:0]     len_o_q;
  logic [AB-1:0]           turn_o_q;

  assign len_o_d = r_side_q.back ? (~len_r_q + {{(LEN_BITS-1){1'b0}}, 1'b1}) : len_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en_o) begin
      ov_q <= rv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      o_side_q <= r_side_q;
      len_o_q  <= len_o_d;
      turn_o_q <= turn_r_q;
    end
  end

  // A stage loads when it is empty or when the stage after it loads too.
  assign en_o = !ov_q || out_ready_i;
  assign en_r = !rv_q || en_o;
  assign en_m = !mv_q || en_r;
  assign en_s[N] = !v_s[N] || en_m;
  for (genvar k = 0; k < N; k++) begin : g_en
    assign en_s[k] = !v_s[k] || en_s[k+1];
  end

  assign in_ready_o  = en_s[0];
  assign out_valid_o = ov_q;
  assign length_o    = len_o_q;
  assign turn_o      = turn_o_q;

  a_ready_when_out_empty : assert property (
    @(posedge clk_i) disable iff (!rst_ni) !ov_q |-> in_ready_o
  ) else $error("input stalled although the output register is empty");

  a_zero_length : assert property (
    @(posedge clk_i) disable iff (!rst_ni) ov_q && o_side_q.zero |-> length_o == '0
  ) else $error("zero vector produced a non-zero length");

  a_forward_nonneg : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      ov_q && !o_side_q.back |-> !length_o[LEN_BITS-1]
  ) else $error("forward segment produced a negative length");

  a_setup_hold : assert property (
    @(posedge clk_i) disable iff (!rst_ni) v_s[0] && !en_s[0] |=> v_s[0]
  ) else $error("set-up stage dropped a stalled transaction");

endmodule
